[rtl/core/mf3_pkg.sv]
// Package with shared types and constants of the 3x3 nonzero median filter.
package mf3_pkg;

  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  localparam logic [10:0] WIDTH_RESET = 11'd1024;
  localparam logic [12:0] HEIGHT_RESET = 13'd1024;

endpackage

[rtl/core/mf3_stream_if.sv]
// Valid/ready stream interface with a generic payload.
interface mf3_stream_if #(
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [PAYLOAD_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/mf3_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/core/mf3_median9.sv]
// Pipelined upper median of the nonzero values among nine signed values.
// Each nonzero value gets a rank (count of strictly smaller values plus equal values
// at lower index), then the value whose rank equals count/2 is picked.
module mf3_median9 #(
  parameter int VALUE_BITS = 32,
  parameter int TAG_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         in_valid,
  input  logic signed [VALUE_BITS-1:0] in_vals [9],
  input  logic [TAG_BITS-1:0]          in_tag,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] out_value,
  output logic [TAG_BITS-1:0]          out_tag
);
  // Stage 1 registers: pairwise compare results.
  logic                         s1_valid;
  logic signed [VALUE_BITS-1:0] s1_vals [9];
  logic [8:0]                   s1_nz;
  logic [8:0]                   s1_less [9];
  logic [TAG_BITS-1:0]          s1_tag;

  // Stage 2 registers: ranks and count.
  logic                         s2_valid;
  logic signed [VALUE_BITS-1:0] s2_vals [9];
  logic [8:0]                   s2_nz;
  logic [3:0]                   s2_rank [9];
  logic [3:0]                   s2_half;
  logic [TAG_BITS-1:0]          s2_tag;

  logic [8:0] less_c [9];
  logic [3:0] rank_c [9];
  logic [3:0] cnt_c;
  logic signed [VALUE_BITS-1:0] pick_c;

  // Value j precedes value i in sorted order when it is smaller, or equal at lower index.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      for (int j = 0; j < 9; j++) begin
        less_c[i][j] = (in_vals[j] != '0) &&
                       ((in_vals[j] < in_vals[i]) || ((in_vals[j] == in_vals[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    cnt_c = '0;
    for (int i = 0; i < 9; i++) begin
      rank_c[i] = '0;
      for (int j = 0; j < 9; j++) begin
        rank_c[i] = rank_c[i] + {3'd0, s1_less[i][j]};
      end
      cnt_c = cnt_c + {3'd0, s1_nz[i]};
    end
  end

  always_comb begin
    pick_c = '0;
    for (int i = 0; i < 9; i++) begin
      if (s2_nz[i] && (s2_rank[i] == s2_half)) begin
        pick_c = s2_vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
    if (advance) begin
      s1_vals <= in_vals;
      s1_less <= less_c;
      s1_tag  <= in_tag;
      for (int i = 0; i < 9; i++) begin
        s1_nz[i] <= (in_vals[i] != '0);
      end
      s2_vals   <= s1_vals;
      s2_nz     <= s1_nz;
      s2_rank   <= rank_c;
      s2_half   <= cnt_c >> 1;
      s2_tag    <= s1_tag;
      out_value <= pick_c;
      out_tag   <= s2_tag;
    end
  end
endmodule

[rtl/core/median3x3_nonzero_filter_top.sv]
// Top level of the streaming 3x3 nonzero median filter.
//
//  channel   direction  payload
//  -------   ---------  ---------------------------------------------------------
//  in_ch     sink       sample_value
//  out_ch    source     filtered_value, out_column, out_row, last_of_run, frame_done
//  cfg       write      cfg_wr_en, cfg_index, cfg_data
//
// An input transaction can be accepted every cycle while in_ch.ready is high. A
// position causes zero to four results, and they leave through the single output
// port one per cycle while out_ch.ready is high. The line stores are read at the
// accepting edge, the median jobs are formed in the next cycle, they pass the median
// pipeline registers s1, s2 and out, and the results are then written into the queue
// that feeds out_ch. Reset clears the counters, the window, the pipeline valids and the
// result queue; the line stores need no clearing pass.
// An output stall never stops the pipeline: results wait in a sixteen-entry queue, and
// the input is held off while more than twelve results are owed.
module median3x3_nonzero_filter_top #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  mf3_stream_if.sink                       in_ch,
  mf3_stream_if.source                     out_ch,
  input  logic                             cfg_wr_en,
  input  logic [mf3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int TAG_BITS = XB + YB + 3; // column, row, last, frame_done, is_zero-unused
  localparam int QD = 16;
  localparam int QB = $clog2(QD);

  // Configuration with clamping.
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [XB:0] w_eff;
  logic [YB:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mf3_pkg::WIDTH_RESET;
      image_height <= mf3_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (mf3_pkg::reg_index_t'(cfg_index))
        mf3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        mf3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) w_eff = (XB+1)'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = (XB+1)'(MAX_WIDTH);
    else w_eff = (XB+1)'(image_width);
    if (image_height == '0) h_eff = (YB+1)'(1);
    else if (32'(image_height) > MAX_HEIGHT) h_eff = (YB+1)'(MAX_HEIGHT);
    else h_eff = (YB+1)'(image_height);
  end

  // Output queue and global advance. The queue must have room for the worst case
  // of results still inside the pipeline plus one more input.
  logic [TAG_BITS+VALUE_BITS-1:0] q_mem [QD];
  logic [QB-1:0] q_wp, q_rp;
  logic [QB:0]   q_cnt;
  logic          advance;

  // Pipeline stage A: accepted input with counters, RAM reads pending.
  logic              a_valid;
  logic [XB-1:0]     a_x;
  logic [YB-1:0]     a_y;
  logic signed [VALUE_BITS-1:0] a_in;
  logic              a_fwd_u, a_fwd_m;
  logic signed [VALUE_BITS-1:0] a_fu, a_fm;

  logic [XB:0]   col_cnt;
  logic [YB:0]   row_cnt;
  logic [XB:0]   xc;
  logic [YB:0]   yc;
  logic          take;

  // Results owed by accepted inputs: reserved, inside the median pipelines or
  // waiting in the queue. This count never exceeds the queue depth.
  logic [QB+2:0] inflight;

  assign take = in_ch.valid && in_ch.ready;
  assign advance = 1'b1;

  always_comb begin
    xc = (col_cnt >= w_eff) ? '0 : col_cnt;
    yc = (row_cnt >= h_eff) ? '0 : row_cnt;
  end

  logic [XB:0] xn;
  logic [YB:0] yn;
  always_comb begin
    xn = xc + 1'b1;
    yn = yc;
    if (xn >= w_eff) begin
      xn = '0;
      yn = yc + 1'b1;
      if (yn >= h_eff) yn = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (take) begin
      col_cnt <= xn;
      row_cnt <= yn;
    end
  end

  // Line stores: upper holds row y-2, middle row y-1.
  logic signed [VALUE_BITS-1:0] up_rd, mid_rd;
  logic signed [VALUE_BITS-1:0] up_v, mid_v;

  mf3_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .wr_en(a_valid), .wr_addr(a_x), .wr_data(mid_v),
    .rd_en(take), .rd_addr(xc[XB-1:0]), .rd_data(up_rd)
  );
  mf3_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .wr_en(a_valid), .wr_addr(a_x), .wr_data(a_in),
    .rd_en(take), .rd_addr(xc[XB-1:0]), .rd_data(mid_rd)
  );

  // Forward when the previous stage-A write hits the address being read (width 1).
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= take;
    end
    if (take) begin
      a_x     <= xc[XB-1:0];
      a_y     <= yc[YB-1:0];
      a_in    <= in_ch.data;
      a_fwd_u <= a_valid && (a_x == xc[XB-1:0]);
      a_fwd_m <= a_valid && (a_x == xc[XB-1:0]);
      a_fu    <= mid_v;
      a_fm    <= a_in;
    end
  end

  assign up_v  = a_fwd_u ? a_fu : up_rd;
  assign mid_v = a_fwd_m ? a_fm : mid_rd;

  // Window: w1 = previous column (rows y-2,y-1,y), w2 = column before.
  logic signed [VALUE_BITS-1:0] w1 [3];
  logic signed [VALUE_BITS-1:0] w2 [3];
  logic signed [VALUE_BITS-1:0] t0 [3];
  assign t0[0] = up_v;
  assign t0[1] = mid_v;
  assign t0[2] = a_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        w1[i] <= '0;
        w2[i] <= '0;
      end
    end else if (a_valid) begin
      w2 <= w1;
      w1 <= t0;
    end
  end

  // Build up to four median jobs for the position in stage A.
  logic signed [VALUE_BITS-1:0] job_vals [4][9];
  logic [3:0]                   job_en;
  logic [TAG_BITS-1:0]          job_tag [4];

  function automatic logic signed [VALUE_BITS-1:0] pick_row(
    input logic mode, input logic ge, input logic [1:0] r,
    input logic signed [VALUE_BITS-1:0] c0, input logic signed [VALUE_BITS-1:0] c1,
    input logic signed [VALUE_BITS-1:0] c2);
    logic signed [VALUE_BITS-1:0] res;
    if (mode == 1'b0) begin
      res = (r == 2'd0) ? (ge ? c0 : c1) : (r == 2'd1) ? c1 : c2;
    end else begin
      res = (r == 2'd0) ? (ge ? c1 : c2) : c2;
    end
    return res;
  endfunction

  always_comb begin
    logic signed [VALUE_BITS-1:0] lc [3];
    logic signed [VALUE_BITS-1:0] rl [3];
    logic [XB-1:0] ocol;
    logic [YB-1:0] orow;
    logic mode, ge, xge1, xlast, ylast;
    int k;
    xge1  = (a_x >= XB'(1));
    xlast = ({1'b0, a_x} == w_eff - 1'b1);
    ylast = ({1'b0, a_y} == h_eff - 1'b1);
    for (int i = 0; i < 3; i++) begin
      lc[i] = (a_x >= XB'(2)) ? w2[i] : w1[i];
      rl[i] = xge1 ? w1[i] : t0[i];
    end
    for (int j = 0; j < 4; j++) begin
      mode = j[1];
      ge = mode ? (a_y >= YB'(1)) : (a_y >= YB'(2));
      orow = mode ? a_y : a_y - 1'b1;
      ocol = j[0] ? XB'(w_eff - 1'b1) : a_x - 1'b1;
      for (int r = 0; r < 3; r++) begin
        k = r * 3;
        if (j[0] == 1'b0) begin
          job_vals[j][k]   = pick_row(mode, ge, 2'(r), lc[0], lc[1], lc[2]);
          job_vals[j][k+1] = pick_row(mode, ge, 2'(r), w1[0], w1[1], w1[2]);
        end else begin
          job_vals[j][k]   = pick_row(mode, ge, 2'(r), rl[0], rl[1], rl[2]);
          job_vals[j][k+1] = pick_row(mode, ge, 2'(r), t0[0], t0[1], t0[2]);
        end
        job_vals[j][k+2] = pick_row(mode, ge, 2'(r), t0[0], t0[1], t0[2]);
      end
      job_en[j] = a_valid && (mode ? ylast : (a_y >= YB'(1))) && (j[0] ? xlast : xge1);
      job_tag[j] = {ocol, orow,
                    1'b0,
                    ({1'b0, ocol} == w_eff - 1'b1) && ({1'b0, orow} == h_eff - 1'b1),
                    1'b0};
    end
  end

  // Four parallel median pipelines, then a merge into the queue.
  logic                         m_valid [4];
  logic signed [VALUE_BITS-1:0] m_value [4];
  logic [TAG_BITS-1:0]          m_tag [4];
  logic [3:0]                   m_last_sel;

  for (genvar g = 0; g < 4; g++) begin : g_med
    logic [TAG_BITS-1:0] tg;
    always_comb begin
      tg = job_tag[g];
      // Last result of this input is the highest enabled job.
      tg[2] = job_en[g] && ((g == 3) ? 1'b1 : (job_en >> (g + 1)) == 4'd0);
    end
    mf3_median9 #(.VALUE_BITS(VALUE_BITS), .TAG_BITS(TAG_BITS)) u_med (
      .clk(clk), .rst(rst), .advance(advance),
      .in_valid(job_en[g]), .in_vals(job_vals[g]), .in_tag(tg),
      .out_valid(m_valid[g]), .out_value(m_value[g]), .out_tag(m_tag[g])
    );
    assign m_last_sel[g] = m_valid[g];
  end

  // Push up to four results per cycle into the queue.
  logic [2:0] push_n;
  logic       pop;
  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    push_n = '0;
    for (int g = 0; g < 4; g++) push_n = push_n + {2'd0, m_last_sel[g]};
  end

  always_ff @(posedge clk) begin
    logic [QB-1:0] p;
    if (rst) begin
      q_wp  <= '0;
      q_rp  <= '0;
      q_cnt <= '0;
    end else begin
      p = q_wp;
      for (int g = 0; g < 4; g++) begin
        if (m_valid[g]) begin
          q_mem[p] <= {m_tag[g], m_value[g]};
          p = p + 1'b1;
        end
      end
      q_wp  <= p;
      if (pop) q_rp <= q_rp + 1'b1;
      q_cnt <= q_cnt + (QB+1)'(push_n) - (QB+1)'(pop);
    end
  end

  // Credit: results reserved by inputs not yet popped. Each input reserves four
  // slots at acceptance; unused reservations return when its jobs are formed.
  logic [2:0] used_n;
  always_comb begin
    used_n = '0;
    for (int g = 0; g < 4; g++) used_n = used_n + {2'd0, job_en[g]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + (take ? (QB+3)'(4) : '0) - (a_valid ? (QB+3)'(4 - used_n) : '0)
                  - (QB+3)'(pop);
    end
  end

  // A new input may reserve four more slots without overrunning the queue.
  assign in_ch.ready = (inflight <= (QB+3)'(QD - 4));

  logic [TAG_BITS+VALUE_BITS-1:0] q_head;
  assign q_head = q_mem[q_rp];
  assign out_ch.valid = (q_cnt != '0);
  assign out_ch.data  = {q_head[TAG_BITS+VALUE_BITS-1:VALUE_BITS+3],
                         q_head[VALUE_BITS+2], q_head[VALUE_BITS+1],
                         q_head[VALUE_BITS-1:0]};
endmodule
